/* rtl/core/gbi_pkg.sv */
package gbi_pkg;

   localparam int FRAC_BITS      = 24;
   localparam int TIME_FRAC      = 24;
   localparam int ADVANCE_FACTOR = 10;
   localparam int GAIN_SHIFT     = 16;

   localparam int WORD_W = 64;
   localparam int WIDE_W = 128;
   localparam int MASS_W = 48;
   localparam int STEP_W = 32;
   localparam int GAIN_W = 32;
   localparam int OP_W   = 2;
   localparam int CSR_W  = 3;

   localparam logic [OP_W-1:0] OP_GRAVITY = 2'd0;
   localparam logic [OP_W-1:0] OP_ADVANCE = 2'd1;
   localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

   localparam logic [CSR_W-1:0] CSR_GAIN        = 3'd0;
   localparam logic [CSR_W-1:0] CSR_START_POS_X = 3'd1;
   localparam logic [CSR_W-1:0] CSR_START_POS_Y = 3'd2;
   localparam logic [CSR_W-1:0] CSR_START_VEL_X = 3'd3;
   localparam logic [CSR_W-1:0] CSR_START_VEL_Y = 3'd4;

   localparam logic [GAIN_W-1:0] GAIN_RESET = 32'd65536;

endpackage

/* rtl/core/gravity_body_integrator_unit.sv */
// Gravity body integrator: one body's position and velocity, signed Q40.24.
// One item at a time: req_stall is high from acceptance until the result is taken.
// Gravity items use the bit-serial divider (four divisions, three when the
// acceleration clips, none for a coincident item), the square root and the
// 32x32 multiplier. The result holds in S_OUT while rsp_stall is high.
// Synchronous active-high reset: state to zero, gain to 1.0, no result pending.
module gravity_body_integrator_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [gbi_pkg::OP_W-1:0]            req_operation,
   input  logic signed [gbi_pkg::WORD_W-1:0]   req_other_pos_x,
   input  logic signed [gbi_pkg::WORD_W-1:0]   req_other_pos_y,
   input  logic [gbi_pkg::MASS_W-1:0]          req_other_mass,
   input  logic [gbi_pkg::STEP_W-1:0]          req_time_step,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [gbi_pkg::WORD_W-1:0]   rsp_pos_x,
   output logic signed [gbi_pkg::WORD_W-1:0]   rsp_pos_y,
   output logic signed [gbi_pkg::WORD_W-1:0]   rsp_vel_x,
   output logic signed [gbi_pkg::WORD_W-1:0]   rsp_vel_y,
   output logic                                rsp_coincident,
   output logic                                rsp_saturated,
   input  logic                                csr_write_enable,
   input  logic [gbi_pkg::CSR_W-1:0]           csr_index,
   input  logic [gbi_pkg::WORD_W-1:0]          csr_write_data
);

   localparam int W  = gbi_pkg::WORD_W;
   localparam int WW = gbi_pkg::WIDE_W;
   localparam int F  = gbi_pkg::FRAC_BITS;
   localparam int SH = gbi_pkg::FRAC_BITS - gbi_pkg::GAIN_SHIFT;

   // Sequencer codes. MUL and DIV are shared units that return to ret_ff; SQRT goes on to S_G_DST.
   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_MUL   = 5'd1;
   localparam logic [4:0] S_DIV   = 5'd2;
   localparam logic [4:0] S_SQRT  = 5'd3;
   localparam logic [4:0] S_OUT   = 5'd4;
   localparam logic [4:0] S_G_OFF = 5'd5;
   localparam logic [4:0] S_G_SQX = 5'd6;
   localparam logic [4:0] S_G_SQY = 5'd7;
   localparam logic [4:0] S_G_DST = 5'd8;
   localparam logic [4:0] S_G_Q1  = 5'd9;
   localparam logic [4:0] S_G_Q2  = 5'd10;
   localparam logic [4:0] S_G_P   = 5'd11;
   localparam logic [4:0] S_G_R   = 5'd12;
   localparam logic [4:0] S_G_PR  = 5'd13;
   localparam logic [4:0] S_G_DV1 = 5'd14;
   localparam logic [4:0] S_G_DV2 = 5'd15;
   localparam logic [4:0] S_A_MUL = 5'd16;
   localparam logic [4:0] S_A_ADD = 5'd17;

   localparam logic [W-1:0] SIGN_BIT = {1'b1, {(W-1){1'b0}}};

   logic [4:0]  state_ff, state_in, ret_ff, ret_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        axis_ff, axis_in;
   logic [gbi_pkg::STEP_W-1:0] t_ff, t_in;
   logic [gbi_pkg::MASS_W-1:0] mass_ff, mass_in;
   logic [W-1:0] ox_ff, ox_in, oy_ff, oy_in;
   logic [W-1:0] mx_ff, mx_in, my_ff, my_in;
   logic         nx_ff, nx_in, ny_ff, ny_in;
   logic [W-1:0] a_ff, a_in, b_ff, b_in;
   logic [WW-1:0] acc_ff, acc_in, num_ff, num_in, s_ff, s_in;
   logic [W-1:0]  rem_ff, rem_in, root_ff, root_in, dist_ff, dist_in, p_ff, p_in;
   logic [W+1:0]  srem_ff, srem_in;
   logic [W-1:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic [W-1:0]  vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic [gbi_pkg::GAIN_W-1:0] gain_ff, gain_in;
   logic [W-1:0]  spx_ff, spx_in, spy_ff, spy_in, svx_ff, svx_in, svy_ff, svy_in;
   logic          coin_ff, coin_in, sat_ff, sat_in;

   // Adds a 128-bit magnitude, negated when neg is set, to a signed word, clipping at the signed limits.
   // The top bit of the result is the clip flag.
   function automatic logic [W:0] add_sat(input logic [W-1:0] v, input logic neg,
                                          input logic [WW-1:0] mag);
      logic [W-1:0] vb;
      logic [W:0]   sum;
      logic         sat;
      vb  = v ^ SIGN_BIT;
      sat = 1'b0;
      sum = {1'b0, vb} + {1'b0, mag[W-1:0]};
      if (mag[WW-1:W] != '0) begin
         sat = 1'b1;
         vb  = neg ? '0 : '1;
      end else if (!neg) begin
         if (sum[W]) begin
            sat = 1'b1;
            vb  = '1;
         end else begin
            vb = sum[W-1:0];
         end
      end else begin
         if (mag[W-1:0] > vb) begin
            sat = 1'b1;
            vb  = '0;
         end else begin
            vb = vb - mag[W-1:0];
         end
      end
      return {sat, vb ^ SIGN_BIT};
   endfunction

   // Offset magnitude a - b with its sign, clipped to the largest positive word.
   function automatic logic [W+1:0] offset_mag(input logic [W-1:0] a,
                                               input logic [W-1:0] b);
      logic [W-1:0] oa, ob, m;
      logic         neg, sat;
      oa  = a ^ SIGN_BIT;
      ob  = b ^ SIGN_BIT;
      neg = oa < ob;
      m   = neg ? ob - oa : oa - ob;
      sat = m[W-1];
      if (sat) begin
         m = {1'b0, {(W-1){1'b1}}};
      end
      return {sat, neg, m};
   endfunction

   logic [31:0]   mul_a_half, mul_b_half;
   logic [W-1:0]  mul_prod;
   logic [WW-1:0] mul_term;
   logic [W:0]    div_part;
   logic          div_ge;
   logic [W+1:0]  sq_part, sq_trial;
   logic          sq_ge;
   logic [W+1:0]  offx, offy;
   logic [W:0]    addr;
   logic [W-1:0]  vel_sel, pos_sel, mag_sel, vmag;
   logic          neg_sel;

   always_comb begin
      // Shared 32x32 multiplier: one partial product per cycle.
      mul_a_half = cnt_ff[0] ? a_ff[63:32] : a_ff[31:0];
      mul_b_half = cnt_ff[1] ? b_ff[63:32] : b_ff[31:0];
      mul_prod   = {32'b0, mul_a_half} * {32'b0, mul_b_half};
      mul_term   = {{W{1'b0}}, mul_prod} << (7'd32 * ({6'b0, cnt_ff[0]} + {6'b0, cnt_ff[1]}));
      // Restoring divider step: numerator shifts out, quotient shifts in.
      div_part = {rem_ff, num_ff[WW-1]};
      div_ge   = div_part >= {1'b0, dist_ff};
      // Square root step: two radicand bits per cycle.
      sq_part  = {srem_ff[W-1:0], num_ff[WW-1:WW-2]};
      sq_trial = {root_ff, 2'b01};
      sq_ge    = sq_part >= sq_trial;

      offx    = offset_mag(ox_ff, pos_x_ff);
      offy    = offset_mag(oy_ff, pos_y_ff);
      vel_sel = axis_ff ? vel_y_ff : vel_x_ff;
      pos_sel = axis_ff ? pos_y_ff : pos_x_ff;
      mag_sel = axis_ff ? my_ff : mx_ff;
      neg_sel = axis_ff ? ny_ff : nx_ff;
      vmag    = vel_sel[W-1] ? (~vel_sel) + 1'b1 : vel_sel;
      addr    = '0;

      state_in = state_ff;  ret_in = ret_ff;  cnt_in = cnt_ff;  axis_in = axis_ff;
      t_in = t_ff;  mass_in = mass_ff;  ox_in = ox_ff;  oy_in = oy_ff;
      mx_in = mx_ff;  my_in = my_ff;  nx_in = nx_ff;  ny_in = ny_ff;
      a_in = a_ff;  b_in = b_ff;  acc_in = acc_ff;  num_in = num_ff;  s_in = s_ff;
      rem_in = rem_ff;  root_in = root_ff;  srem_in = srem_ff;
      dist_in = dist_ff;  p_in = p_ff;
      pos_x_in = pos_x_ff;  pos_y_in = pos_y_ff;  vel_x_in = vel_x_ff;  vel_y_in = vel_y_ff;
      gain_in = gain_ff;  spx_in = spx_ff;  spy_in = spy_ff;  svx_in = svx_ff;  svy_in = svy_ff;
      coin_in = coin_ff;  sat_in = sat_ff;

      if (csr_write_enable) begin
         case (csr_index)
            gbi_pkg::CSR_GAIN:        gain_in = csr_write_data[gbi_pkg::GAIN_W-1:0];
            gbi_pkg::CSR_START_POS_X: spx_in = csr_write_data;
            gbi_pkg::CSR_START_POS_Y: spy_in = csr_write_data;
            gbi_pkg::CSR_START_VEL_X: svx_in = csr_write_data;
            gbi_pkg::CSR_START_VEL_Y: svy_in = csr_write_data;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               t_in    = req_time_step;
               mass_in = req_other_mass;
               ox_in   = req_other_pos_x;
               oy_in   = req_other_pos_y;
               coin_in = 1'b0;
               sat_in  = 1'b0;
               axis_in = 1'b0;
               case (req_operation)
                  gbi_pkg::OP_GRAVITY: state_in = S_G_OFF;
                  gbi_pkg::OP_ADVANCE: state_in = S_A_MUL;
                  gbi_pkg::OP_RESTART: begin
                     pos_x_in = spx_ff;  pos_y_in = spy_ff;
                     vel_x_in = svx_ff;  vel_y_in = svy_ff;
                     state_in = S_OUT;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_MUL: begin
            acc_in = acc_ff + mul_term;
            cnt_in = cnt_ff + 7'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = ret_ff;
            end
         end
         S_DIV: begin
            rem_in = div_ge ? W'(div_part - {1'b0, dist_ff}) : div_part[W-1:0];
            num_in = {num_ff[WW-2:0], div_ge};
            cnt_in = cnt_ff - 7'd1;
            if (cnt_ff == '0) begin
               state_in = ret_ff;
            end
         end
         S_SQRT: begin
            srem_in = sq_ge ? sq_part - sq_trial : sq_part;
            root_in = {root_ff[W-2:0], sq_ge};
            num_in  = {num_ff[WW-3:0], 2'b00};
            cnt_in  = cnt_ff - 7'd1;
            if (cnt_ff == '0) begin
               state_in = S_G_DST;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         S_G_OFF: begin
            mx_in = offx[W-1:0];  nx_in = offx[W];
            my_in = offy[W-1:0];  ny_in = offy[W];
            sat_in = sat_ff | offx[W+1] | offy[W+1];
            a_in = offx[W-1:0];  b_in = offx[W-1:0];
            acc_in = '0;  cnt_in = '0;  ret_in = S_G_SQX;  state_in = S_MUL;
         end
         S_G_SQX: begin
            s_in = acc_ff;
            a_in = my_ff;  b_in = my_ff;
            acc_in = '0;  cnt_in = '0;  ret_in = S_G_SQY;  state_in = S_MUL;
         end
         S_G_SQY: begin
            num_in  = s_ff + acc_ff;
            srem_in = '0;  root_in = '0;
            cnt_in  = 7'(W - 1);
            state_in = S_SQRT;
         end
         S_G_DST: begin
            dist_in = root_ff;
            if (root_ff == '0) begin
               coin_in  = 1'b1;
               state_in = S_OUT;
            end else begin
               a_in = W'(gain_ff);  b_in = W'(mass_ff);
               acc_in = '0;  cnt_in = '0;  ret_in = S_G_Q1;  state_in = S_MUL;
            end
         end
         S_G_Q1: begin
            num_in = acc_ff << F;
            rem_in = '0;  cnt_in = 7'(WW - 1);  ret_in = S_G_Q2;  state_in = S_DIV;
         end
         S_G_Q2: begin
            if (num_ff[WW-1:WW-F] != '0) begin
               p_in = '1;  sat_in = 1'b1;  state_in = S_G_R;
            end else begin
               num_in = num_ff << F;
               rem_in = '0;  cnt_in = 7'(WW - 1);  ret_in = S_G_P;  state_in = S_DIV;
            end
         end
         S_G_P: begin
            if ((num_ff >> (W - SH)) != '0) begin
               p_in = '1;  sat_in = 1'b1;
            end else begin
               p_in = W'(num_ff << SH);
            end
            state_in = S_G_R;
         end
         S_G_R: begin
            num_in = {{W{1'b0}}, mag_sel} << F;
            rem_in = '0;  cnt_in = 7'(WW - 1);  ret_in = S_G_PR;  state_in = S_DIV;
         end
         S_G_PR: begin
            a_in = p_ff;  b_in = num_ff[W-1:0];
            acc_in = '0;  cnt_in = '0;  ret_in = S_G_DV1;  state_in = S_MUL;
         end
         S_G_DV1: begin
            a_in = acc_ff[F+W-1:F];  b_in = W'(t_ff);
            acc_in = '0;  cnt_in = '0;  ret_in = S_G_DV2;  state_in = S_MUL;
         end
         S_G_DV2: begin
            addr   = add_sat(vel_sel, neg_sel, acc_ff >> gbi_pkg::TIME_FRAC);
            sat_in = sat_ff | addr[W];
            if (axis_ff) begin
               vel_y_in = addr[W-1:0];  state_in = S_OUT;
            end else begin
               vel_x_in = addr[W-1:0];  axis_in = 1'b1;  state_in = S_G_R;
            end
         end
         S_A_MUL: begin
            a_in = vmag;
            b_in = W'(t_ff) * W'(gbi_pkg::ADVANCE_FACTOR);
            acc_in = '0;  cnt_in = '0;  ret_in = S_A_ADD;  state_in = S_MUL;
         end
         S_A_ADD: begin
            addr   = add_sat(pos_sel, vel_sel[W-1], acc_ff >> gbi_pkg::TIME_FRAC);
            sat_in = sat_ff | addr[W];
            if (axis_ff) begin
               pos_y_in = addr[W-1:0];  state_in = S_OUT;
            end else begin
               pos_x_in = addr[W-1:0];  axis_in = 1'b1;  state_in = S_A_MUL;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ret_ff   <= S_IDLE;
         pos_x_ff <= '0;  pos_y_ff <= '0;  vel_x_ff <= '0;  vel_y_ff <= '0;
         gain_ff  <= gbi_pkg::GAIN_RESET;
         spx_ff <= '0;  spy_ff <= '0;  svx_ff <= '0;  svy_ff <= '0;
         coin_ff <= 1'b0;  sat_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         pos_x_ff <= pos_x_in;  pos_y_ff <= pos_y_in;
         vel_x_ff <= vel_x_in;  vel_y_ff <= vel_y_in;
         gain_ff  <= gain_in;
         spx_ff <= spx_in;  spy_ff <= spy_in;  svx_ff <= svx_in;  svy_ff <= svy_in;
         coin_ff <= coin_in;  sat_ff <= sat_in;
      end
      cnt_ff <= cnt_in;  axis_ff <= axis_in;  t_ff <= t_in;  mass_ff <= mass_in;
      ox_ff <= ox_in;  oy_ff <= oy_in;  mx_ff <= mx_in;  my_ff <= my_in;
      nx_ff <= nx_in;  ny_ff <= ny_in;  a_ff <= a_in;  b_ff <= b_in;
      acc_ff <= acc_in;  num_ff <= num_in;  s_ff <= s_in;
      rem_ff <= rem_in;  root_ff <= root_in;  srem_ff <= srem_in;
      dist_ff <= dist_in;  p_ff <= p_in;
   end

   // The result item is the body state itself, which holds while it waits.
   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = (state_ff == S_OUT);
   assign rsp_pos_x      = pos_x_ff;
   assign rsp_pos_y      = pos_y_ff;
   assign rsp_vel_x      = vel_x_ff;
   assign rsp_vel_y      = vel_y_ff;
   assign rsp_coincident = coin_ff;
   assign rsp_saturated  = sat_ff;

endmodule
